/* hw/rtl/kperm_pkg.sv */
`default_nettype none

package kperm_pkg;

  // Default size of the value alphabet
  localparam int MAX_N_DEF = 16;

  // Digit store depth (longest permutation)
  localparam int MAX_K = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_TOTAL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHOOSE = 2'd1;

  localparam logic [4:0] TOTAL_RESET  = 5'd16;
  localparam logic [5:0] CHOOSE_RESET = 6'd0;

  // Decoded iteration setup, taken on a restart
  typedef struct packed {
    logic       ok;  // k fits within n and the digit store
    logic [4:0] n;   // values to draw from, 1..min(31, MAX_N)
    logic [4:0] k;   // digits per permutation, valid when ok
  } iter_cfg_t;

endpackage

`default_nettype wire

/* hw/rtl/k_permutation_enumerator_top.sv */
`default_nettype none

// Ordered k-permutation enumerator. Each input transfer requests the next
// permutation of k distinct values out of 0..n-1 in lexicographic order,
// delivered as k output transfers (position 0 first, last on the final
// digit), or a single exhausted transfer once the sequence runs out, was
// never started, or a restart finds the setup not ok. restart=1 reloads n and
// k from the configuration registers first; register writes take effect only
// at the next restart. The block handles one request at a time and drops
// in_ready while it works. A single candidate comparator tests one value per
// cycle against a mask of values in use. A restart fills every digit with the
// smallest values; a continuing request walks digits back, for each one
// trying candidate values above it (at most n), then refills the tail by
// scanning values upward, then emits the k digits. No clearing pass at reset.
module k_permutation_enumerator_top #(
  parameter int MAX_N = kperm_pkg::MAX_N_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output      logic                             in_ready,
  input  wire logic                             in_restart,
  output      logic                             out_valid,
  input  wire logic                             out_ready,
  output      logic [3:0]                       out_element,
  output      logic [3:0]                       out_position,
  output      logic                             out_last,
  output      logic                             out_exhausted,
  input  wire logic                             cfg_valid,
  output      logic                             cfg_ready,
  input  wire logic [kperm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [kperm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int VW = (MAX_N > 1) ? $clog2(MAX_N) : 1;  // value width
  localparam int CW = VW + 1;                            // candidate width

  typedef enum logic [2:0] {
    S_IDLE,
    S_DROP,
    S_PROBE,
    S_FILL,
    S_EMIT,
    S_EXH
  } state_t;

  kperm_pkg::iter_cfg_t setup;

  state_t         state_r;
  logic           active_r;
  logic [4:0]     n_r;
  logic [4:0]     k_r;
  logic [4:0]     idx_r;
  logic [CW-1:0]  cand_r;
  logic [MAX_N-1:0] used_r;
  logic [VW-1:0]  digits_r [kperm_pkg::MAX_K];

  logic           out_valid_r;
  logic [3:0]     out_element_r;
  logic [3:0]     out_position_r;
  logic           out_last_r;
  logic           out_exhausted_r;

  logic [VW-1:0]  cur_digit;
  logic           cand_over;
  logic           cand_free;
  logic           at_last;
  logic           out_free;
  logic           out_load;

  function automatic logic [MAX_N-1:0] val_bit(input logic [VW-1:0] v);
    logic [MAX_N-1:0] b;
    b    = '0;
    b[v] = 1'b1;
    return b;
  endfunction

  kperm_cfg #(
    .MAX_N (MAX_N)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .setup     (setup)
  );

  // Shared candidate compare and digit read
  assign cur_digit = digits_r[idx_r[3:0]];
  assign cand_over = 8'(cand_r) >= 8'(n_r);
  assign cand_free = !used_r[cand_r[VW-1:0]];
  assign at_last   = (idx_r + 5'd1) == k_r;
  assign out_free  = !out_valid_r || out_ready;
  // output register takes a new result this cycle
  assign out_load  = out_free && (state_r inside {S_EMIT, S_EXH});

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (in_restart) begin
              n_r <= setup.n;
              k_r <= setup.k;
              if (setup.ok) begin
                active_r <= 1'b1;
                used_r   <= '0;
                idx_r    <= 5'd0;
                cand_r   <= '0;
                state_r  <= S_FILL;
              end else begin
                active_r <= 1'b0;
                state_r  <= S_EXH;
              end
            end else if (active_r) begin
              idx_r   <= k_r - 5'd1;
              state_r <= S_DROP;
            end else begin
              state_r <= S_EXH;
            end
          end
        end
        // release the current digit, try values above it
        S_DROP: begin
          used_r  <= used_r & ~val_bit(cur_digit);
          cand_r  <= {1'b0, cur_digit} + CW'(1);
          state_r <= S_PROBE;
        end
        S_PROBE: begin
          if (cand_over) begin
            if (idx_r == 5'd0) begin
              active_r <= 1'b0;
              state_r  <= S_EXH;
            end else begin
              idx_r   <= idx_r - 5'd1;
              state_r <= S_DROP;
            end
          end else if (cand_free) begin
            digits_r[idx_r[3:0]] <= cand_r[VW-1:0];
            used_r  <= used_r | val_bit(cand_r[VW-1:0]);
            idx_r   <= idx_r + 5'd1;
            cand_r  <= '0;
            state_r <= S_FILL;
          end else begin
            cand_r <= cand_r + CW'(1);
          end
        end
        // tail gets the smallest unused values in ascending order
        S_FILL: begin
          if (idx_r == k_r) begin
            idx_r   <= 5'd0;
            state_r <= S_EMIT;
          end else begin
            if (cand_free) begin
              digits_r[idx_r[3:0]] <= cand_r[VW-1:0];
              used_r <= used_r | val_bit(cand_r[VW-1:0]);
              idx_r  <= idx_r + 5'd1;
            end
            cand_r <= cand_r + CW'(1);
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r     <= 1'b1;
            out_element_r   <= 4'(cur_digit);
            out_position_r  <= idx_r[3:0];
            out_last_r      <= at_last;
            out_exhausted_r <= 1'b0;
            if (at_last) begin
              state_r <= S_IDLE;
            end else begin
              idx_r <= idx_r + 5'd1;
            end
          end
        end
        S_EXH: begin
          if (out_free) begin
            out_valid_r     <= 1'b1;
            out_element_r   <= 4'd0;
            out_position_r  <= 4'd0;
            out_last_r      <= 1'b1;
            out_exhausted_r <= 1'b1;
            state_r         <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready      = (state_r == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_element   = out_element_r;
  assign out_position  = out_position_r;
  assign out_last      = out_last_r;
  assign out_exhausted = out_exhausted_r;

  // After a request transfer, in_ready is low in the next cycle
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready held after request transfer");

  // An exhausted result carries zero fields and the last mark
  a_exh_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_exhausted) |->
      (out_last && out_element == 4'd0 && out_position == 4'd0))
    else $error("exhausted result with nonzero fields");

  // A running iteration has a usable digit count
  a_active_k: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (k_r != 5'd0 && k_r <= n_r))
    else $error("active iteration with bad k");

  // While emitting, exactly k values are marked in use
  a_used_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> ($countones(used_r) == int'(k_r)))
    else $error("in-use mask does not match digit count");

endmodule

`default_nettype wire

/* hw/rtl/kperm_cfg.sv */
`default_nettype none

module kperm_cfg #(
  parameter int MAX_N = kperm_pkg::MAX_N_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_valid,
  input  wire logic [kperm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [kperm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output kperm_pkg::iter_cfg_t                  setup
);

  logic        [4:0] total_r;
  logic signed [5:0] choose_r;
  logic        [4:0] n_eff;
  logic signed [7:0] n_s;
  logic signed [7:0] k_s;

  // Register file; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r  <= kperm_pkg::TOTAL_RESET;
      choose_r <= kperm_pkg::CHOOSE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        kperm_pkg::REG_TOTAL:  total_r  <= cfg_wdata[4:0];
        kperm_pkg::REG_CHOOSE: choose_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // n: zero reads as one, saturate at MAX_N. k: a negative value is added to n,
  // and a result of zero or below means n.
  always_comb begin
    n_eff = (total_r == 5'd0) ? 5'd1 : total_r;
    if (int'(n_eff) > MAX_N) begin
      n_eff = 5'(MAX_N);
    end
    n_s = signed'({3'b000, n_eff});
    k_s = 8'(choose_r);
    if (choose_r[5]) begin
      k_s = k_s + n_s;
    end
    if (k_s <= 8'sd0) begin
      k_s = n_s;
    end
    setup.ok = (k_s <= n_s) && (k_s <= 8'(signed'(kperm_pkg::MAX_K)));
    setup.n  = n_eff;
    setup.k  = k_s[4:0];
  end

endmodule

`default_nettype wire
